// ----- rtl/kmta_pkg.sv -----
// Shared types, constants and key map tables for the keyboard matrix decoder.
package kmta_pkg;

    localparam int NUM_ROWS = 8;
    localparam int NUM_COLS = 5;
    localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
    localparam int CHAR_W   = 7;
    localparam int IDX_W    = $clog2(NUM_KEYS);
    localparam int ROW_IDX_W = $clog2(NUM_ROWS);
    localparam int SCAN_W   = NUM_ROWS * NUM_COLS;
    localparam int OUT_W    = ((CHAR_W + 7) / 8) * 8;

    localparam int SYM_ROW  = 0;
    localparam int SYM_COL  = 1;
    localparam int CAPS_ROW = 5;
    localparam int CAPS_COL = 0;

    localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;
    localparam logic [CHAR_W-1:0] LOWER_A     = 7'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z     = 7'h7A;

    typedef logic [CHAR_W-1:0] char_t;

    // What one lane shows the merge stage.
    typedef struct packed {
        logic  pend;    // lane still holds at least one character
        logic  single;  // the shown character is the lane's last one
        char_t chr;     // lowest pending character of the lane
    } lane_status_t;

    localparam char_t PLAIN_MAP [NUM_KEYS] = '{
        7'h20, 7'h00, 7'h6D, 7'h6E, 7'h62,
        7'h30, 7'h39, 7'h38, 7'h37, 7'h36,
        7'h0A, 7'h6C, 7'h6B, 7'h6A, 7'h68,
        7'h70, 7'h6F, 7'h69, 7'h75, 7'h79,
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35,
        7'h00, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67
    };

    // Zero means no symbol substitute; fall back to the plain character.
    localparam char_t SYM_MAP [NUM_KEYS] = '{
        7'h00, 7'h00, 7'h3F, 7'h2C, 7'h2A,
        7'h5F, 7'h29, 7'h28, 7'h27, 7'h26,
        7'h00, 7'h3D, 7'h2B, 7'h2D, 7'h5C,
        7'h5D, 7'h5B, 7'h3E, 7'h3C, 7'h7B,
        7'h21, 7'h40, 7'h23, 7'h24, 7'h25,
        7'h00, 7'h21, 7'h3F, 7'h2C, 7'h2E,
        7'h60, 7'h7C, 7'h5E, 7'h7E, 7'h7D,
        7'h3A, 7'h3B, 7'h22, 7'h2F, 7'h3D
    };

    function automatic char_t map_key(input logic [IDX_W-1:0] idx,
                                      input logic sym, input logic caps);
        char_t plain;
        char_t symc;
        begin
            plain = PLAIN_MAP[idx];
            symc  = SYM_MAP[idx];
            if (sym && (symc != '0)) begin
                map_key = symc;
            end else if (caps && (plain >= LOWER_A) && (plain <= LOWER_Z)) begin
                map_key = plain - CASE_OFFSET;
            end else begin
                map_key = plain;
            end
        end
    endfunction

endpackage

// ----- rtl/kmta_lane.sv -----
// One row lane: keeps its previous row, finds new presses and queues their characters.
module kmta_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [kmta_pkg::ROW_IDX_W-1:0]      row_idx,
    input  logic [kmta_pkg::NUM_COLS-1:0]       row_bits,
    input  logic                                sym,
    input  logic                                caps,
    input  logic                                load,
    input  logic                                pop,
    output kmta_pkg::lane_status_t              status
);
    import kmta_pkg::*;

    logic [NUM_COLS-1:0] prev_reg, prev_next;
    logic [NUM_COLS-1:0] pend_reg, pend_next;
    char_t               chars_reg [NUM_COLS];
    char_t               chars_next [NUM_COLS];
    logic [NUM_COLS-1:0] pressed;
    logic [NUM_COLS-1:0] hit;
    logic [NUM_COLS-1:0] low_oh;
    logic [IDX_W-1:0]    base_idx;
    char_t               sel_chr;

    assign base_idx = IDX_W'(row_idx) * IDX_W'(NUM_COLS);
    assign pressed  = prev_reg & ~row_bits;

    always_comb begin
        for (int b = 0; b < NUM_COLS; b++) begin
            chars_next[b] = map_key(base_idx + IDX_W'(b), sym, caps);
            hit[b]        = pressed[b] && (chars_next[b] != '0);
        end
    end

    // Isolate the lowest pending key of this row.
    assign low_oh = pend_reg & (~pend_reg + NUM_COLS'(1));

    always_comb begin
        sel_chr = '0;
        for (int b = 0; b < NUM_COLS; b++) begin
            sel_chr = sel_chr | (chars_reg[b] & {CHAR_W{low_oh[b]}});
        end
    end

    always_comb begin
        prev_next = prev_reg;
        pend_next = pend_reg;
        if (load) begin
            prev_next = row_bits;
            pend_next = hit;
        end else if (pop) begin
            pend_next = pend_reg & ~low_oh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '1;
            pend_reg <= '0;
        end else begin
            prev_reg <= prev_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int b = 0; b < NUM_COLS; b++) begin
                chars_reg[b] <= chars_next[b];
            end
        end
    end

    assign status.pend   = |pend_reg;
    assign status.single = (pend_reg & ~low_oh) == '0;
    assign status.chr    = sel_chr;

endmodule

// ----- rtl/kmta_merge.sv -----
// Merge stage: picks the lowest lane with a pending character and drives the output register.
module kmta_merge (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  kmta_pkg::lane_status_t              lane_status [kmta_pkg::NUM_ROWS],
    output logic [kmta_pkg::NUM_ROWS-1:0]       lane_pop,
    output logic                                in_ready,
    output logic                                out_valid,
    output kmta_pkg::char_t                     out_chr,
    output logic                                out_last,
    input  logic                                out_ready
);
    import kmta_pkg::*;

    logic [NUM_ROWS-1:0] lane_any;
    logic [NUM_ROWS-1:0] lane_single;
    logic [NUM_ROWS-1:0] sel_oh;
    logic                any_pend;
    logic                advance;
    logic                sel_last;
    char_t               sel_chr;

    logic  valid_reg, valid_next;
    char_t chr_reg;
    logic  last_reg;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            lane_any[r]    = lane_status[r].pend;
            lane_single[r] = lane_status[r].single;
        end
    end

    assign sel_oh   = lane_any & (~lane_any + NUM_ROWS'(1));
    assign any_pend = |lane_any;

    always_comb begin
        sel_chr = '0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            sel_chr = sel_chr | (lane_status[r].chr & {CHAR_W{sel_oh[r]}});
        end
    end

    // Last of the scan: the chosen lane shows its final key and no later lane waits.
    assign sel_last = (|(sel_oh & lane_single)) && ((lane_any & ~sel_oh) == '0);

    assign advance  = !valid_reg || out_ready;
    assign lane_pop = advance ? sel_oh : '0;
    assign in_ready = !any_pend || (advance && sel_last);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = any_pend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && any_pend) begin
            chr_reg  <= sel_chr;
            last_reg <= sel_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_chr   = chr_reg;
    assign out_last  = last_reg;

endmodule

// ----- rtl/keyboard_matrix_to_ascii_core.sv -----
// Top level of the keyboard matrix scan decoder: row lanes plus merge stage.
//
//  Channel  Direction  Payload                                   Transaction
//  s_       in         tdata[39:0] = rows 0..7, 5 bits each      one matrix scan
//  m_       out        tdata[6:0] character, tlast last of scan  one character
//
// Rate: the merge stage passes a scan's new presses on one character per cycle while
// m_tready is high; the merge stage's single output register sets that rate.
// The next scan is accepted in the cycle the previous scan's last character moves
// into the output register, so scans follow back to back.
// Reset: previous rows read all released, no characters pending, output empty.
// Stalls: m_tready low holds the output register and all pending characters.
module keyboard_matrix_to_ascii_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_space_to_b [4:0], row_zero_to_six [9:5], row_enter_to_h [14:10],
    // row_p_to_y [19:15], row_one_to_five [24:20], row_caps_to_v [29:25],
    // row_q_to_t [34:30], row_a_to_g [39:35]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // character [6:0], zero [7]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);
    import kmta_pkg::*;

    lane_status_t        lane_status [NUM_ROWS];
    logic [NUM_ROWS-1:0] lane_pop;
    logic                load;
    logic                sym;
    logic                caps;
    char_t               out_chr;

    assign load = s_tvalid && s_tready;
    assign sym  = !s_tdata[SYM_ROW * NUM_COLS + SYM_COL];
    assign caps = !s_tdata[CAPS_ROW * NUM_COLS + CAPS_COL];

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
        kmta_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .row_idx  (ROW_IDX_W'(r)),
            .row_bits (s_tdata[r*NUM_COLS +: NUM_COLS]),
            .sym      (sym),
            .caps     (caps),
            .load     (load),
            .pop      (lane_pop[r]),
            .status   (lane_status[r])
        );
    end

    kmta_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lane_status (lane_status),
        .lane_pop    (lane_pop),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_chr     (out_chr),
        .out_last    (m_tlast),
        .out_ready   (m_tready)
    );

    assign m_tdata = {{(OUT_W - CHAR_W){1'b0}}, out_chr};

endmodule
